FILE: hw/rtl/vef_pkg.sv
// Shared widths, codes and defaults of the vertical edge filter.
package vef_pkg;

   localparam int PIX_W       = 8;
   localparam int WIDTH_W     = 9;
   localparam int HEIGHT_W    = 12;
   // the row counter runs one past the frame height while draining
   localparam int ROW_W       = HEIGHT_W + 1;
   // holds width * height for any register value the line store depth allows
   localparam int COUNT_W     = WIDTH_W + HEIGHT_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = HEIGHT_W;
   localparam int MAX_LINE_DEF = 256;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

endpackage

FILE: hw/rtl/vef_line_buf.sv
// Upper and middle line stores with registered read and same-entry forwarding.
module vef_line_buf #(
   parameter int MAX_LINE = vef_pkg::MAX_LINE_DEF,
   parameter int AW       = $clog2(MAX_LINE)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [vef_pkg::PIX_W-1:0] wr_upper,
   input  logic [vef_pkg::PIX_W-1:0] wr_middle,
   output logic [vef_pkg::PIX_W-1:0] rd_upper,
   output logic [vef_pkg::PIX_W-1:0] rd_middle
);

   logic [vef_pkg::PIX_W-1:0] upper_mem [MAX_LINE];
   logic [vef_pkg::PIX_W-1:0] middle_mem [MAX_LINE];

   logic [vef_pkg::PIX_W-1:0] upper_q_ff;
   logic [vef_pkg::PIX_W-1:0] middle_q_ff;
   logic [vef_pkg::PIX_W-1:0] fwd_upper_ff;
   logic [vef_pkg::PIX_W-1:0] fwd_middle_ff;
   logic                      fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         upper_q_ff    <= upper_mem[rd_addr];
         middle_q_ff   <= middle_mem[rd_addr];
         fwd_upper_ff  <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   // read and write of one entry at the same edge: memory returns old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : upper_q_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : middle_q_ff;

endmodule

FILE: hw/rtl/vertical_edge_filter_3x3_top.sv
// The completing item is held in the window stage, then its result in the output register.
// Output trails input by one line plus one pixel; drain items push out the tail of a frame.
// Throughput: one item per cycle unless output stalls; one read and write port per store.
// Reset: synchronous; clears position, count, window and handshake state, width/height to 256.
// Line stores are not cleared after reset and need no clearing pass.
module vertical_edge_filter_3x3_top #(
   parameter int MAX_LINE = vef_pkg::MAX_LINE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] pixel_in
   input  logic                           req_tuser,   // [0] operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] pixel_out
   output logic                           rsp_tlast,   // frame_end
   input  logic                           csr_we,
   input  logic [vef_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [vef_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_LINE);
   localparam int PW = vef_pkg::PIX_W;

   typedef enum logic [1:0] {
      SEL_CENTER,
      SEL_SAVED,
      SEL_EDGE
   } out_sel_type;

   // configuration
   logic [vef_pkg::WIDTH_W-1:0]  width_ff;
   logic [vef_pkg::HEIGHT_W-1:0] height_ff;
   logic [vef_pkg::WIDTH_W-1:0]  eff_w;
   logic [vef_pkg::HEIGHT_W-1:0] eff_h;
   logic [vef_pkg::COUNT_W-1:0]  total_ff;
   logic [vef_pkg::COUNT_W:0]    total_prod;

   // position of the next item
   logic [AW-1:0]                col_ff, col_in, col_cur;
   logic [vef_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [vef_pkg::COUNT_W-1:0]  count_ff, count_in, count_inc;

   logic                         pixel_phase;
   logic                         take;
   logic                         emit_saved, emit_win, emit, last;
   logic                         pass_win;
   logic                         col_wrap;
   out_sel_type                  sel;

   // window stage
   logic                         s1_valid_ff;
   logic                         s1_emit_ff;
   logic                         s1_last_ff;
   out_sel_type                  s1_sel_ff;
   logic [AW-1:0]                s1_col_ff;
   logic [PW-1:0]                s1_newv_ff;
   logic                         s1_move;
   logic [PW-1:0]                win_ff [9];
   logic [PW-1:0]                lb_top, lb_mid;

   logic [PW+1:0]                sum_right, sum_left;
   logic [PW-1:0]                edge_val, value;

   // output register
   logic                         out_valid_ff;
   logic [PW-1:0]                out_data_ff;
   logic                         out_last_ff;
   logic                         out_ready;

   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = vef_pkg::WIDTH_W'(1);
      end else if (32'(width_ff) > 32'(MAX_LINE)) begin
         eff_w = vef_pkg::WIDTH_W'(MAX_LINE);
      end
      eff_h = (height_ff == '0) ? vef_pkg::HEIGHT_W'(1) : height_ff;
      total_prod = (vef_pkg::COUNT_W + 1)'(eff_w) * (vef_pkg::COUNT_W + 1)'(eff_h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= vef_pkg::WIDTH_RESET;
         height_ff <= vef_pkg::HEIGHT_RESET;
         total_ff  <= vef_pkg::COUNT_W'(32'(vef_pkg::WIDTH_RESET)
                                         * 32'(vef_pkg::HEIGHT_RESET));
      end else begin
         total_ff <= total_prod[vef_pkg::COUNT_W-1:0];
         if (csr_we) begin
            case (csr_addr)
               vef_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[vef_pkg::WIDTH_W-1:0];
               vef_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------- position and classification ----------------
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && (!s1_emit_ff || out_ready);
   assign req_tready = !s1_valid_ff || s1_move;

   always_comb begin
      col_cur     = (32'(col_ff) >= 32'(eff_w)) ? '0 : col_ff;
      pixel_phase = row_ff < vef_pkg::ROW_W'(eff_h);
      take        = req_tvalid && req_tready
                    && !(req_tuser == vef_pkg::OP_DRAIN && pixel_phase);

      // column zero from row two on: right border pixel of two rows back
      emit_saved = (col_cur == '0) && (row_ff >= vef_pkg::ROW_W'(2));
      emit_win   = (col_cur != '0) && (row_ff != '0);
      emit       = emit_saved || emit_win;
      pass_win   = (row_ff == vef_pkg::ROW_W'(1)) || (row_ff == vef_pkg::ROW_W'(eff_h))
                   || (col_cur == AW'(1));
      if (emit_saved) begin
         sel = SEL_SAVED;
      end else if (pass_win) begin
         sel = SEL_CENTER;
      end else begin
         sel = SEL_EDGE;
      end

      count_inc = count_ff + vef_pkg::COUNT_W'(1);
      last      = emit && (count_inc >= total_ff);

      col_wrap = (32'(col_cur) + 32'd1) >= 32'(eff_w);
      col_in   = col_wrap ? '0 : AW'(32'(col_cur) + 32'd1);
      row_in   = col_wrap ? row_ff + vef_pkg::ROW_W'(1) : row_ff;
      count_in = emit ? count_inc : count_ff;
      if (last) begin
         col_in   = '0;
         row_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
      end else if (take) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         count_ff <= count_in;
      end
   end

   // ---------------- line stores ----------------
   vef_line_buf #(
      .MAX_LINE (MAX_LINE),
      .AW       (AW)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (take),
      .rd_addr   (col_cur),
      .wr_en     (s1_move),
      .wr_addr   (s1_col_ff),
      .wr_upper  (lb_mid),
      .wr_middle (s1_newv_ff),
      .rd_upper  (lb_top),
      .rd_middle (lb_mid)
   );

   // ---------------- window stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
         s1_sel_ff   <= SEL_CENTER;
      end else if (req_tready) begin
         s1_valid_ff <= take;
         s1_emit_ff  <= take && emit;
         s1_last_ff  <= last;
         s1_sel_ff   <= sel;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff  <= col_cur;
         s1_newv_ff <= pixel_phase ? req_tdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_move) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]     <= win_ff[i*3 + 1];
            win_ff[i*3 + 1] <= win_ff[i*3 + 2];
         end
         win_ff[2] <= lb_top;
         win_ff[5] <= lb_mid;
         win_ff[8] <= s1_newv_ff;
      end
   end

   // right column is the incoming one, left column is the current middle column
   always_comb begin
      sum_right = (PW+2)'(lb_top) + {1'b0, lb_mid, 1'b0} + (PW+2)'(s1_newv_ff);
      sum_left  = (PW+2)'(win_ff[1]) + {1'b0, win_ff[4], 1'b0} + (PW+2)'(win_ff[7]);
      if (sum_right <= sum_left) begin
         edge_val = '0;
      end else if ((sum_right - sum_left) > (PW+2)'(255)) begin
         edge_val = '1;
      end else begin
         edge_val = PW'(sum_right - sum_left);
      end
      case (s1_sel_ff)
         SEL_EDGE: value = edge_val;
         SEL_CENTER, SEL_SAVED: value = win_ff[5];
         default:  value = win_ff[5];
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move && s1_emit_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_emit_ff) begin
         out_data_ff <= value;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !req_tready)
      else $error("input accepted while window stage is stalled");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && last) |=> (col_ff == '0 && row_ff == '0 && count_ff == '0))
      else $error("position not restarted after final item of frame");

   a_count_below_total: assert property (@(posedge clock) disable iff (reset)
      count_ff < total_ff)
      else $error("emitted count reached frame size without restart");

   a_row_bounded: assert property (@(posedge clock) disable iff (reset)
      row_ff <= vef_pkg::ROW_W'(eff_h) + vef_pkg::ROW_W'(1))
      else $error("row counter ran past the drain row");
`endif

endmodule

FILE: test/vertical_edge_filter_3x3_top_tb.sv
// Self-checking stream testbench for the 3x3 vertical edge filter.
`timescale 1ns / 1ps

module vertical_edge_filter_3x3_top_tb;

   localparam int LINE_MAX    = vef_pkg::MAX_LINE_DEF;
   localparam int ITEM_TARGET = 1800;
   localparam int WD_LIMIT    = 3000;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic                           is_csr;
      logic [vef_pkg::CSR_IDX_W-1:0]  addr;
      logic [vef_pkg::CSR_DATA_W-1:0] wdata;
      logic                           op;
      logic [vef_pkg::PIX_W-1:0]      pix;
      logic                           typed;
      logic [vef_pkg::PIX_W-1:0]      exp_pix;
      logic                           exp_last;
   } stim_row_type;

   typedef struct {
      logic [vef_pkg::PIX_W-1:0] pix;
      logic                      last;
   } out_pixel_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;   // [7:0] pixel_in
   logic                           req_tuser = 1'b0; // [0] operation
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;        // [7:0] pixel_out
   logic                           rsp_tlast;        // frame_end
   logic                           csr_we = 1'b0;
   logic [vef_pkg::CSR_IDX_W-1:0]  csr_addr = '0;
   logic [vef_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   vertical_edge_filter_3x3_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [vef_pkg::WIDTH_W-1:0]  reg_width  = vef_pkg::WIDTH_RESET;
   logic [vef_pkg::HEIGHT_W-1:0] reg_height = vef_pkg::HEIGHT_RESET;
   logic [vef_pkg::PIX_W-1:0]    pred_upper  [LINE_MAX];
   logic [vef_pkg::PIX_W-1:0]    pred_middle [LINE_MAX];
   logic [vef_pkg::PIX_W-1:0]    pred_win    [9];
   int unsigned                  pred_col   = 0;
   int unsigned                  pred_row   = 0;
   int unsigned                  pred_count = 0;

   out_pixel_type expected_pixels [$];
   out_pixel_type head_pixel;

   int  fail_count      = 0;
   int  items_in        = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  frames_done     = 0;
   int  frames_cut      = 0;
   int  idle_cycles     = 0;
   int  max_width_seen  = 0;
   bit  burst           = 1'b0;
   bit  rx_long_hold    = 1'b0;

   // directed part: 1x1 frame via out-of-range regs, a 3x3 frame with a
   // clamped-high center, then a 2x2 frame
   localparam int N_DIR = 30;
   stim_row_type dir_rows [N_DIR] = '{
      '{1'b1, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b1, vef_pkg::CSR_FRAME_HEIGHT, 12'd0, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h12, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b1},
      '{1'b1, vef_pkg::CSR_FRAME_WIDTH,  12'd3, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b1, vef_pkg::CSR_FRAME_HEIGHT, 12'd3, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h07, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h09, 1'b1, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'hFF, 1'b1, 8'h07, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h00, 1'b1, 8'hFF, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h05, 1'b1, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'hFF, 1'b1, 8'hFF, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b1, 8'h05, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b1, 8'hFF, 1'b1},
      '{1'b1, vef_pkg::CSR_FRAME_WIDTH,  12'd2, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b1, vef_pkg::CSR_FRAME_HEIGHT, 12'd2, vef_pkg::OP_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h80, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h01, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'hFE, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_PIXEL, 8'h7F, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, vef_pkg::CSR_FRAME_WIDTH,  12'd0, vef_pkg::OP_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0}
   };

   initial begin
      for (int i = 0; i < LINE_MAX; i++) begin
         pred_upper[i]  = '0;
         pred_middle[i] = '0;
      end
      for (int i = 0; i < 9; i++) pred_win[i] = '0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // advance the filter by one item; returns the pixel it releases, if any
   task automatic edge_predict(input logic op, input logic [vef_pkg::PIX_W-1:0] pix,
                               output bit emit, output logic [vef_pkg::PIX_W-1:0] val,
                               output bit last);
      int unsigned w, h, c, r;
      logic [vef_pkg::PIX_W-1:0] nv, top, mid, tail;
      int right_sum, left_sum, diff;
      bit in_pixels;
      emit = 1'b0;
      val  = '0;
      last = 1'b0;
      w = 32'(reg_width);
      if (w == 0) w = 1;
      else if (w > LINE_MAX) w = LINE_MAX;
      h = 32'(reg_height);
      if (h == 0) h = 1;
      in_pixels = pred_row < h;
      // drain ticks are dropped while pixels are still due
      if (op == vef_pkg::OP_DRAIN && in_pixels) return;
      if (pred_col >= w) pred_col = 0;
      c  = pred_col;
      r  = pred_row;
      nv = in_pixels ? pix : '0;

      tail = pred_upper[w-1];
      top  = pred_upper[c];
      mid  = pred_middle[c];
      pred_upper[c]  = mid;
      pred_middle[c] = nv;
      for (int i = 0; i < 3; i++) begin
         pred_win[i*3]   = pred_win[i*3+1];
         pred_win[i*3+1] = pred_win[i*3+2];
      end
      pred_win[2] = top;
      pred_win[5] = mid;
      pred_win[8] = nv;

      if (c == 0 && r >= 2) begin
         // right-border pixel of two rows back
         val  = tail;
         emit = 1'b1;
      end else if (c >= 1 && r >= 1) begin
         if (r == 1 || r == h || c == 1 || c == w) begin
            val = pred_win[4];
         end else begin
            right_sum = int'(pred_win[2]) + 2 * int'(pred_win[5]) + int'(pred_win[8]);
            left_sum  = int'(pred_win[0]) + 2 * int'(pred_win[3]) + int'(pred_win[6]);
            diff = right_sum - left_sum;
            if (diff < 0) diff = 0;
            if (diff > 255) diff = 255;
            val = diff[vef_pkg::PIX_W-1:0];
         end
         emit = 1'b1;
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      pred_col = c;
      pred_row = r;

      if (emit) begin
         pred_count++;
         if (pred_count >= w * h) begin
            last       = 1'b1;
            pred_col   = 0;
            pred_row   = 0;
            pred_count = 0;
         end
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic idle_gap();
      int n;
      if (burst) return;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_item(input logic op, input logic [vef_pkg::PIX_W-1:0] pix,
                            input bit typed, input logic [vef_pkg::PIX_W-1:0] t_pix,
                            input bit t_last);
      bit emit, last;
      logic [vef_pkg::PIX_W-1:0] val;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      edge_predict(op, pix, emit, val, last);
      if (typed) expected_pixels.push_back('{t_pix, t_last});
      else if (emit) expected_pixels.push_back('{val, last});
      items_in++;
      @(negedge clock);
   endtask

   // registers change only with the filter drained and settled
   task automatic write_reg(input logic [vef_pkg::CSR_IDX_W-1:0] addr,
                            input logic [vef_pkg::CSR_DATA_W-1:0] data);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == vef_pkg::CSR_FRAME_WIDTH) reg_width = data[vef_pkg::WIDTH_W-1:0];
      else reg_height = data[vef_pkg::HEIGHT_W-1:0];
      pred_col   = 0;
      pred_row   = 0;
      pred_count = 0;
   endtask

   // result side: random back-pressure, one long hold on request
   initial begin
      int stall_left, run_left, r;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (rx_long_hold) begin
            rx_long_hold = 1'b0;
            stall_left   = LONG_HOLD;
            run_left     = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_tready <= 1'b1;
            run_left--;
         end else begin
            r = $urandom_range(0, 9);
            if (r < 2) run_left = $urandom_range(20, 100);
            else if (r >= 6) stall_left = gap_len();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_pixels.size() == 0) begin
            $error("unexpected item: pixel_out %0d frame_end %0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            head_pixel = expected_pixels.pop_front();
            if (rsp_tdata !== head_pixel.pix) begin
               $error("pixel_out expected %0d got %0d", head_pixel.pix, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== head_pixel.last) begin
               $error("frame_end expected %0b got %0b", head_pixel.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("timeout with %0d items outstanding", expected_pixels.size());
            $display("vertical_edge_filter_3x3_top_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int w_reg, h_reg, ew, eh, npx, cut, frame_no, r;
      bit keep, cut_frame, need_cfg;
      logic op;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIR; i++) begin
         if (dir_rows[i].is_csr) begin
            write_reg(dir_rows[i].addr, dir_rows[i].wdata);
         end else begin
            idle_gap();
            send_item(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
                      dir_rows[i].exp_pix, dir_rows[i].exp_last);
         end
      end
      items_sent = items_in;

      frame_no = 0;
      need_cfg = 1'b1;
      w_reg = 3;
      h_reg = 3;
      while (items_sent < ITEM_TARGET) begin
         keep      = 1'b0;
         cut_frame = 1'b0;
         if (frame_no == 1) begin
            w_reg = $urandom_range(6, 12);
            h_reg = 6;
         end else if (frame_no == 3) begin
            w_reg = 256 + $urandom_range(0, 255);
            h_reg = 3;
         end else if (frame_no == 6) begin
            w_reg = $urandom_range(3, 8);
            h_reg = 4095;
            cut_frame = 1'b1;
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
               w_reg = $urandom_range(0, 2);
               h_reg = $urandom_range(0, 6);
            end else if (r == 1) begin
               w_reg = $urandom_range(1, 10);
               h_reg = $urandom_range(0, 2);
            end else if (r < 7 && !need_cfg) begin
               keep = 1'b1;
            end else begin
               w_reg = $urandom_range(3, 12);
               h_reg = $urandom_range(3, 8);
            end
            if (r >= 18) cut_frame = 1'b1;
         end
         if (!keep) begin
            write_reg(vef_pkg::CSR_FRAME_WIDTH, vef_pkg::CSR_DATA_W'(w_reg));
            write_reg(vef_pkg::CSR_FRAME_HEIGHT, vef_pkg::CSR_DATA_W'(h_reg));
         end

         ew  = (w_reg == 0) ? 1 : ((w_reg > LINE_MAX) ? LINE_MAX : w_reg);
         eh  = (h_reg == 0) ? 1 : h_reg;
         npx = ew * eh;
         if (ew > max_width_seen) max_width_seen = ew;
         if (!cut_frame) cut = npx;
         else if (frame_no == 6) cut = 4 * ew + $urandom_range(0, ew - 1);
         else cut = $urandom_range(0, npx - 1);

         burst = (frame_no == 1) || ($urandom_range(0, 3) == 0);
         // output held off while this frame streams in, so the filter backs up
         if (frame_no == 1) rx_long_hold = 1'b1;

         for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               idle_gap();
               send_item(vef_pkg::OP_DRAIN, vef_pkg::PIX_W'($urandom_range(0, 255)),
                         1'b0, '0, 1'b0);
            end
            idle_gap();
            send_item(vef_pkg::OP_PIXEL, vef_pkg::PIX_W'($urandom_range(0, 255)),
                      1'b0, '0, 1'b0);
            items_sent++;
         end
         if (!cut_frame) begin
            for (int k = 0; k <= ew; k++) begin
               op = ($urandom_range(0, 7) == 0) ? vef_pkg::OP_PIXEL : vef_pkg::OP_DRAIN;
               idle_gap();
               send_item(op, vef_pkg::PIX_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
               items_sent++;
            end
         end

         need_cfg = cut_frame || (frame_no == 3);
         frames_done++;
         if (cut_frame) frames_cut++;
         frame_no++;
      end
      req_tvalid <= 1'b0;

      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("ran %0d random frames (%0d cut short), widths to %0d, height up to 4095",
               frames_done, frames_cut, max_width_seen);
      $display("%0d items sent, %0d output pixels checked", items_in, results_checked);
      if (fail_count == 0) begin
         $display("vertical_edge_filter_3x3_top_tb OK");
      end else begin
         $display("vertical_edge_filter_3x3_top_tb NOT OK");
      end
      $finish;
   end

endmodule
